/* hw/rtl/u8cc_pkg.sv */
// shared types, constants and codes for the utf-8 character counter
package u8cc_pkg;

    localparam int COUNT_BITS = 16;
    localparam int DATA_BITS  = 8;
    localparam int OUT_BITS   = 16;

    localparam logic [DATA_BITS-1:0] CONT_LOW   = 8'h80;
    localparam logic [DATA_BITS-1:0] CONT_HIGH  = 8'hBF;
    localparam logic [DATA_BITS-1:0] LEAD2_LOW  = 8'hC2;
    localparam logic [DATA_BITS-1:0] LEAD2_HIGH = 8'hDF;
    localparam logic [DATA_BITS-1:0] LEAD3_LOW  = 8'hE0;
    localparam logic [DATA_BITS-1:0] LEAD3_HIGH = 8'hEF;

    localparam logic [15:0] CP_MIN3         = 16'h0800;
    localparam logic [7:0]  CP_RESERVED_HI  = 8'hEE;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_TWO     = 2'd1,
        PEND_THREE_A = 2'd2,
        PEND_THREE_B = 2'd3
    } pend_t;

    typedef struct packed {
        pend_t                 kind;
        logic [3:0]            lead_nibble;
        logic [DATA_BITS-1:0]  first_cont;
        logic [COUNT_BITS-1:0] count;
    } u8cc_state_t;

    localparam u8cc_state_t STATE_RESET = '{
        kind:        PEND_NONE,
        lead_nibble: 4'd0,
        first_cont:  '0,
        count:       '0
    };

endpackage

/* hw/rtl/u8cc_if.sv */
// valid/ready channel interfaces for byte input and count output

interface u8cc_in_if;
    import u8cc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] data_byte;
    logic                 last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8cc_out_if;
    import u8cc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] char_count;

    modport source (output valid, output char_count, input ready);
    modport sink   (input valid, input char_count, output ready);
endinterface

/* hw/rtl/u8cc_step.sv */
// per-byte state update: sequence tracking and saturating count
module u8cc_step (
    input  u8cc_pkg::u8cc_state_t              state,
    input  logic [u8cc_pkg::DATA_BITS-1:0]     data_byte,
    input  logic                               last_byte,
    output u8cc_pkg::u8cc_state_t              state_next,
    output logic [u8cc_pkg::COUNT_BITS-1:0]    count_out
);
    import u8cc_pkg::*;

    logic [1:0]            add;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] count_sat;
    logic [15:0]           code_point;
    logic                  seq_ok;
    u8cc_state_t           upd;

    assign code_point = {state.lead_nibble, state.first_cont[5:0], data_byte[5:0]};
    assign seq_ok     = (state.first_cont inside {[CONT_LOW:CONT_HIGH]})
                     && (data_byte inside {[CONT_LOW:CONT_HIGH]})
                     && (code_point >= CP_MIN3)
                     && (code_point[15:8] != CP_RESERVED_HI);

    always_comb
    begin
        upd = state;
        add = 2'd0;
        case (state.kind)
            PEND_NONE:
            begin
                if (data_byte inside {[LEAD2_LOW:LEAD2_HIGH]})
                begin
                    upd.kind = PEND_TWO;
                    add      = last_byte ? 2'd1 : 2'd0;
                end
                else if (data_byte inside {[LEAD3_LOW:LEAD3_HIGH]})
                begin
                    upd.kind        = PEND_THREE_A;
                    upd.lead_nibble = data_byte[3:0];
                    add             = last_byte ? 2'd1 : 2'd0;
                end
                else
                begin
                    add = 2'd1;
                end
            end
            PEND_TWO:
            begin
                upd.kind = PEND_NONE;
                add      = (data_byte inside {[CONT_LOW:CONT_HIGH]}) ? 2'd1 : 2'd2;
            end
            PEND_THREE_A:
            begin
                upd.kind       = PEND_THREE_B;
                upd.first_cont = data_byte;
                add            = last_byte ? 2'd2 : 2'd0;
            end
            PEND_THREE_B:
            begin
                upd.kind = PEND_NONE;
                add      = seq_ok ? 2'd1 : 2'd3;
            end
            default:
            begin
                upd.kind = PEND_NONE;
                add      = 2'd1;
            end
        endcase
    end

    // count never exceeds its cap, so a carry out means saturation
    assign sum       = {1'b0, state.count} + {{(COUNT_BITS-1){1'b0}}, add};
    assign count_sat = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];

    always_comb
    begin
        if (last_byte)
        begin
            state_next = STATE_RESET;
        end
        else
        begin
            state_next       = upd;
            state_next.count = count_sat;
        end
    end

    assign count_out = count_sat;

endmodule

/* hw/rtl/utf8_char_counter_top.sv */
// top level of the streaming utf-8 character counter
// Bytes of a string arrive one per item with a mark on the final byte; one item with the
// character count follows each string, saturating at its maximum. A byte is taken every
// clock cycle while results are drained: each byte lands in an input register, the
// sequence state and saturating count are updated in one pass of compares and an add,
// and the count of a finished string is loaded into a result register as its final byte
// leaves the input register. Only a full result register that is not being taken holds
// back the final byte of the next string, and the input register then stalls the byte feed.
module utf8_char_counter_top (
    input  logic        clk,
    input  logic        rst_n,
    u8cc_in_if.sink     feed,
    u8cc_out_if.source  result
);
    import u8cc_pkg::*;

    logic                  in_valid_reg;
    logic [DATA_BITS-1:0]  data_reg;
    logic                  last_reg;
    u8cc_state_t           state_reg;
    u8cc_state_t           state_next;
    logic [COUNT_BITS-1:0] step_count;
    logic                  out_valid_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  advance;

    u8cc_step u_step (
        .state      (state_reg),
        .data_byte  (data_reg),
        .last_byte  (last_reg),
        .state_next (state_next),
        .count_out  (step_count)
    );

    // a final byte may move only when the result register is free or being emptied
    assign advance    = in_valid_reg && (!last_reg || !out_valid_reg || result.ready);
    assign feed.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (feed.ready)
            begin
                in_valid_reg <= feed.valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed.ready && feed.valid)
        begin
            data_reg <= feed.data_byte;
            last_reg <= feed.last_byte;
        end
        if (advance && last_reg)
        begin
            count_reg <= step_count;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.char_count = OUT_BITS'(count_reg);

endmodule

/* hw/rtl/u8cc_checker.sv */
// port-level checks for the utf-8 character counter, bound to the top level
module u8cc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [u8cc_pkg::OUT_BITS-1:0] char_count
);
    import u8cc_pkg::*;

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped before it was taken");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(char_count))
        else $error("stalled result item changed");

    // every string holds at least one character
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> char_count != '0)
        else $error("result item with zero characters");

    // bytes are only held back by a result that cannot leave
    a_feed_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("byte feed stalled with the result register free");

endmodule

bind utf8_char_counter_top u8cc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (feed.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .char_count (result.char_count)
);

/* verif/utf8_char_counter_top_tb.sv */
// testbench for the streaming utf-8 character counter: directed and random strings
`timescale 1ns / 100ps

module utf8_char_counter_top_tb;
    import u8cc_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_BYTES   = 660;
    localparam int TAIL_BYTES     = 150;
    localparam int DRAIN_CYCLES   = 6;

    logic clk;
    logic rst_n;

    u8cc_in_if  feed_if ();
    u8cc_out_if result_if ();

    utf8_char_counter_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_if),
        .result (result_if)
    );

    // own copy of the counter state
    pend_t                 tally_kind   = PEND_NONE;
    logic [3:0]            tally_nibble = '0;
    logic [DATA_BITS-1:0]  tally_second = '0;
    logic [COUNT_BITS-1:0] char_total   = '0;

    logic [OUT_BITS-1:0]   awaited_counts [$];
    logic [DATA_BITS-1:0]  str_bytes [$];

    bit bursts_on   = 1'b1;
    int mismatches  = 0;
    int sent_bytes  = 0;
    int quiet_cycles = 0;
    int ready_stall = 0;

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    function automatic bit is_cont(input logic [DATA_BITS-1:0] b);
        return b >= CONT_LOW && b <= CONT_HIGH;
    endfunction

    function automatic void add_chars(input int unsigned n);
        longint sum;
        sum = longint'(char_total) + longint'(n);
        if (sum > longint'(COUNT_MAX))
            char_total = COUNT_MAX;
        else
            char_total = COUNT_BITS'(sum);
    endfunction

    task automatic tally_byte(input logic [DATA_BITS-1:0] b, input logic last);
        logic [15:0] cp;
        case (tally_kind)
            PEND_NONE:
            begin
                if (b < LEAD2_LOW || b > LEAD3_HIGH)
                begin
                    add_chars(1);
                end
                else if (b < LEAD3_LOW)
                begin
                    tally_kind = PEND_TWO;
                    // a lead cut off by the end of the string counts alone
                    if (last)
                        add_chars(1);
                end
                else
                begin
                    tally_kind   = PEND_THREE_A;
                    tally_nibble = b[3:0];
                    if (last)
                        add_chars(1);
                end
            end
            PEND_TWO:
            begin
                add_chars(is_cont(b) ? 1 : 2);
                tally_kind = PEND_NONE;
            end
            PEND_THREE_A:
            begin
                tally_second = b;
                tally_kind   = PEND_THREE_B;
                if (last)
                    add_chars(2);
            end
            default:
            begin
                cp = {tally_nibble, tally_second[5:0], b[5:0]};
                if (is_cont(tally_second) && is_cont(b) && cp >= CP_MIN3
                    && cp[15:8] != CP_RESERVED_HI)
                    add_chars(1);
                else
                    add_chars(3);
                tally_kind = PEND_NONE;
            end
        endcase
        if (last)
        begin
            awaited_counts.push_back(OUT_BITS'(char_total));
            tally_kind   = PEND_NONE;
            tally_nibble = '0;
            tally_second = '0;
            char_total   = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [OUT_BITS-1:0] got,
                                   input logic [OUT_BITS-1:0] want);
        $display("ERROR at %0t: %s: char_count %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // called just after a rising edge; returns at the edge where the item is taken
    task automatic send_byte(input logic [DATA_BITS-1:0] b, input logic last);
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            feed_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        feed_if.valid     <= 1'b1;
        feed_if.data_byte <= b;
        feed_if.last_byte <= last;
        do
            @(posedge clk);
        while (!feed_if.ready);
        tally_byte(b, last);
        sent_bytes++;
    endtask

    task automatic send_string;
        foreach (str_bytes[i])
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    // appends one character, mostly well formed, sometimes broken or stray
    task automatic add_random_char;
        logic [DATA_BITS-1:0] lead;
        case ($urandom_range(0, 9))
            0, 1, 2: str_bytes.push_back(8'($urandom_range(0, 8'h7F)));
            3: str_bytes.push_back(8'($urandom_range(0, 8'hFF)));
            4, 5:
            begin
                str_bytes.push_back(8'($urandom_range(LEAD2_LOW, LEAD2_HIGH)));
                str_bytes.push_back(8'($urandom_range(CONT_LOW, CONT_HIGH)));
            end
            6, 7:
            begin
                case ($urandom_range(0, 3))
                    0: lead = LEAD3_LOW;
                    1: lead = 8'hEE;
                    default: lead = 8'($urandom_range(LEAD3_LOW, LEAD3_HIGH));
                endcase
                str_bytes.push_back(lead);
                // aim at the reserved window now and then
                if (lead == 8'hEE && $urandom_range(0, 1) == 0)
                    str_bytes.push_back(8'($urandom_range(8'hB8, 8'hBB)));
                else
                    str_bytes.push_back(8'($urandom_range(CONT_LOW, CONT_HIGH)));
                str_bytes.push_back(8'($urandom_range(CONT_LOW, CONT_HIGH)));
            end
            8:
            begin
                lead = 8'($urandom_range(LEAD2_LOW, LEAD3_HIGH));
                str_bytes.push_back(lead);
                str_bytes.push_back(8'($urandom_range(0, 8'hFF)));
                if (lead >= LEAD3_LOW)
                    str_bytes.push_back(8'($urandom_range(0, 8'hFF)));
            end
            default:
            begin
                if ($urandom_range(0, 1) == 0)
                    str_bytes.push_back(8'($urandom_range(CONT_LOW, 8'hC1)));
                else
                    str_bytes.push_back(8'($urandom_range(8'hF0, 8'hFF)));
            end
        endcase
    endtask

    task automatic test_directed;
        str_bytes = '{8'h00};             send_string();
        str_bytes = '{8'hFF};             send_string();
        str_bytes = '{8'hC1, 8'h80};      send_string();
        str_bytes = '{8'hC2, 8'hBF};      send_string();
        // lead followed by a non-continuation still swallows it
        str_bytes = '{8'hDF, 8'hC0};      send_string();
        str_bytes = '{8'hC2};             send_string();
        str_bytes = '{8'hE0};             send_string();
        str_bytes = '{8'hE0, 8'hA0};      send_string();
        // overlong three-byte form
        str_bytes = '{8'hE0, 8'h9F, 8'hBF}; send_string();
        // both edges of the reserved window
        str_bytes = '{8'hEE, 8'hB8, 8'h80}; send_string();
        str_bytes = '{8'hEE, 8'hBB, 8'hBF}; send_string();
        str_bytes = '{8'hEF, 8'hBF, 8'hBF}; send_string();
    endtask

    task automatic test_random_strings(input int budget);
        int start;
        int keep;
        start = sent_bytes;
        while (sent_bytes - start < budget)
        begin
            str_bytes.delete();
            repeat ($urandom_range(1, 10)) add_random_char();
            // cut some strings short, often inside a sequence
            if ($urandom_range(0, 3) == 0)
            begin
                keep = $urandom_range(1, str_bytes.size());
                while (str_bytes.size() > keep)
                    void'(str_bytes.pop_back());
            end
            send_string();
        end
    endtask

    // result side: compare each taken count, stall in bursts
    always @(posedge clk)
    begin
        if (result_if.valid && result_if.ready)
        begin
            if (awaited_counts.size() == 0)
                report_mismatch("unexpected count", result_if.char_count, '0);
            else if (result_if.char_count !== awaited_counts[0])
                report_mismatch("wrong count", result_if.char_count,
                                awaited_counts.pop_front());
            else
                void'(awaited_counts.pop_front());
        end
        if (ready_stall > 0)
        begin
            ready_stall--;
            result_if.ready <= 1'b0;
        end
        else if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            ready_stall = $urandom_range(0, 4);
            result_if.ready <= 1'b0;
        end
        else
        begin
            result_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (feed_if.valid && feed_if.ready) || (result_if.valid && result_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        feed_if.valid     <= 1'b0;
        feed_if.data_byte <= '0;
        feed_if.last_byte <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_strings(RANDOM_BYTES);
        bursts_on = 1'b0;
        test_random_strings(TAIL_BYTES);
        feed_if.valid <= 1'b0;

        while (awaited_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
